### design/lzsd_pkg.sv
// ----------------------------------------------------------------------------
// lzsd_pkg
// shared types and constants for the lzss ring decoder
// ----------------------------------------------------------------------------
package lzsd_pkg;

   localparam int HISTORY_SIZE_DEF = 4096;

   localparam logic [11:0] START_POS      = 12'hFEE;
   localparam logic [4:0]  LEN_BIAS       = 5'd3;
   localparam logic [3:0]  FLAGS_PER_BYTE = 4'd8;
   localparam int          LIT_FLAG_BIT   = 7;
   localparam int          LEN_BITS       = 4;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_DATA,
      PH_SECOND,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear;
      logic wr_en;
      logic rd_en;
   } hist_ctl_type;

endpackage

### design/lzsd_history.sv
// ----------------------------------------------------------------------------
// lzsd_history
// history window memory; entries not written since the last clear read as zero
// ----------------------------------------------------------------------------
module lzsd_history
   import lzsd_pkg::*;
#(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEF,
   localparam int AW = $clog2(HISTORY_SIZE)
) (
   input  logic          clock,
   input  logic          reset,
   input  hist_ctl_type  hist_ctl,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]    mem [HISTORY_SIZE];
   logic [7:0]    rd_data_ff;
   logic          rd_hit_ff;
   logic          rd_hit_in;
   logic [AW:0]   fill_ff;
   logic [AW:0]   fill_in;
   logic [AW-1:0] rd_offset;

   // entries are written in order from the start position, so a fill count covers them
   assign rd_offset = rd_addr - AW'(START_POS);
   assign rd_hit_in = {1'b0, rd_offset} < fill_ff;

   always_comb begin
      fill_in = fill_ff;
      if (hist_ctl.clear) begin
         fill_in = '0;
      end else if (hist_ctl.wr_en && (fill_ff != (AW+1)'(HISTORY_SIZE))) begin
         fill_in = fill_ff + (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hist_ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (hist_ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
         rd_hit_ff  <= rd_hit_in;
      end
   end

   assign rd_data = rd_hit_ff ? rd_data_ff : 8'd0;

endmodule

### design/lzsd_ctrl.sv
// ----------------------------------------------------------------------------
// lzsd_ctrl
// decode sequencer: flag, literal and reference parsing, copy loop, output register
// ----------------------------------------------------------------------------
module lzsd_ctrl
   import lzsd_pkg::*;
#(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEF,
   localparam int AW = $clog2(HISTORY_SIZE)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic [7:0]    req_in_byte,
   input  logic          req_first,
   input  logic          req_last_in,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output logic [7:0]    rsp_out_byte,
   output logic          rsp_run_last,
   output logic          rsp_stream_done,
   input  logic          csr_write_en,
   input  logic [23:0]   csr_write_data,
   output hist_ctl_type  hist_ctl,
   output logic [AW-1:0] hist_wr_addr,
   output logic [7:0]    hist_wr_data,
   output logic [AW-1:0] hist_rd_addr,
   input  logic [7:0]    hist_rd_data
);

   state_type     state_ff, state_in;
   phase_type     phase_ff, phase_in;
   logic [7:0]    flag_bits_ff, flag_bits_in;
   logic [3:0]    flags_left_ff, flags_left_in;
   logic [7:0]    ref_first_ff, ref_first_in;
   logic [23:0]   out_count_ff, out_count_in;
   logic [23:0]   out_length_ff, out_length_in;
   logic [AW-1:0] write_pos_ff, write_pos_in;
   logic [AW-1:0] rd_pos_ff, rd_pos_in;
   logic [4:0]    remain_ff, remain_in;
   logic          lit_ff, lit_in;
   logic [7:0]    byte_ff, byte_in;
   logic          first_ff, first_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_run_last_ff, rsp_run_last_in;
   logic          rsp_done_ff, rsp_done_in;

   logic          req_take;
   logic          slot_free;
   phase_type     eff_phase;
   phase_type     chk_phase;
   logic [23:0]   eff_count;
   logic [23:0]   cnt_next;
   logic          hit;
   logic          more;
   logic [3:0]    flags_left_dec;
   logic [7:0]    emit_byte;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   assign eff_phase = first_ff ? PH_FLAG : phase_ff;
   assign eff_count = first_ff ? 24'd0 : out_count_ff;
   assign chk_phase = ((eff_phase != PH_DONE) && (eff_count >= out_length_ff)) ? PH_DONE
                                                                                 : eff_phase;

   assign cnt_next       = out_count_ff + 24'd1;
   assign hit            = (cnt_next == out_length_ff);
   assign more           = !lit_ff && (remain_ff != 5'd1) && !hit;
   assign flags_left_dec = (flags_left_ff != 4'd0) ? flags_left_ff - 4'd1 : 4'd0;
   assign emit_byte      = lit_ff ? byte_ff : hist_rd_data;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            priority if ((chk_phase == PH_DATA) && flag_bits_ff[LIT_FLAG_BIT]) begin
               state_in = ST_WRITE;
            end else if (chk_phase == PH_SECOND) begin
               state_in = ST_READ;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            if (slot_free) begin
               state_in = more ? ST_READ : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in        = phase_ff;
      flag_bits_in    = flag_bits_ff;
      flags_left_in   = flags_left_ff;
      ref_first_in    = ref_first_ff;
      out_count_in    = out_count_ff;
      out_length_in   = csr_write_en ? csr_write_data : out_length_ff;
      write_pos_in    = write_pos_ff;
      rd_pos_in       = rd_pos_ff;
      remain_in       = remain_ff;
      lit_in          = lit_ff;
      byte_in         = byte_ff;
      first_in        = first_ff;
      last_in         = last_ff;
      rsp_byte_in     = rsp_byte_ff;
      rsp_run_last_in = rsp_run_last_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_valid_in    = rsp_stall ? rsp_valid_ff : 1'b0;
      hist_ctl        = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               byte_in  = req_in_byte;
               first_in = req_first;
               last_in  = req_last_in;
            end
         end
         ST_DECODE: begin
            hist_ctl.clear = first_ff;
            if (first_ff) begin
               flag_bits_in  = 8'd0;
               flags_left_in = 4'd0;
               ref_first_in  = 8'd0;
               out_count_in  = 24'd0;
               write_pos_in  = AW'(START_POS);
            end
            phase_in = chk_phase;
            unique case (chk_phase)
               PH_FLAG: begin
                  flag_bits_in  = byte_ff;
                  flags_left_in = FLAGS_PER_BYTE;
                  phase_in      = last_ff ? PH_DONE : PH_DATA;
               end
               PH_DATA: begin
                  if (flag_bits_ff[LIT_FLAG_BIT]) begin
                     lit_in = 1'b1;
                  end else begin
                     ref_first_in = byte_ff;
                     phase_in     = last_ff ? PH_DONE : PH_SECOND;
                  end
               end
               PH_SECOND: begin
                  lit_in    = 1'b0;
                  remain_in = {1'b0, ref_first_ff[LEN_BITS-1:0]} + LEN_BIAS;
                  rd_pos_in = AW'({byte_ff, ref_first_ff[7:LEN_BITS]});
               end
               PH_DONE: begin
                  phase_in = PH_DONE;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
         ST_READ: begin
            hist_ctl.rd_en = 1'b1;
         end
         ST_WRITE: begin
            if (slot_free) begin
               hist_ctl.wr_en  = 1'b1;
               write_pos_in    = write_pos_ff + AW'(1);
               out_count_in    = cnt_next;
               rsp_valid_in    = 1'b1;
               rsp_byte_in     = emit_byte;
               rsp_run_last_in = !more;
               rsp_done_in     = hit;
               if (more) begin
                  rd_pos_in = rd_pos_ff + AW'(1);
                  remain_in = remain_ff - 5'd1;
               end
               priority if (hit) begin
                  phase_in = PH_DONE;
               end else if (!more) begin
                  flag_bits_in  = {flag_bits_ff[6:0], 1'b0};
                  flags_left_in = flags_left_dec;
                  if (last_ff) begin
                     phase_in = PH_DONE;
                  end else begin
                     phase_in = (flags_left_dec != 4'd0) ? PH_DATA : PH_FLAG;
                  end
               end else begin
                  phase_in = phase_ff;
               end
            end
         end
         default: begin
            hist_ctl = '0;
         end
      endcase
   end

   assign hist_wr_addr = write_pos_ff;
   assign hist_wr_data = emit_byte;
   assign hist_rd_addr = rd_pos_ff;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_last    = rsp_run_last_ff;
   assign rsp_stream_done = rsp_done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         phase_ff      <= PH_FLAG;
         flag_bits_ff  <= 8'd0;
         flags_left_ff <= 4'd0;
         ref_first_ff  <= 8'd0;
         out_count_ff  <= 24'd0;
         out_length_ff <= 24'd0;
         write_pos_ff  <= AW'(START_POS);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         flag_bits_ff  <= flag_bits_in;
         flags_left_ff <= flags_left_in;
         ref_first_ff  <= ref_first_in;
         out_count_ff  <= out_count_in;
         out_length_ff <= out_length_in;
         write_pos_ff  <= write_pos_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff       <= rd_pos_in;
      remain_ff       <= remain_in;
      lit_ff          <= lit_in;
      byte_ff         <= byte_in;
      first_ff        <= first_in;
      last_ff         <= last_in;
      rsp_byte_ff     <= rsp_byte_in;
      rsp_run_last_ff <= rsp_run_last_in;
      rsp_done_ff     <= rsp_done_in;
   end

endmodule

### design/lzss_ring_decoder.sv
// ----------------------------------------------------------------------------
// lzss_ring_decoder
// lzss decompressor with a 4096-byte history window
// ----------------------------------------------------------------------------
// usage
//   req channel: one compressed byte per request, with req_first marking the
//   start of a stream (history and state cleared) and req_last_in the end.
//   rsp channel: one decompressed byte per response; rsp_run_last marks the
//   last byte caused by an input request, rsp_stream_done the byte that
//   reaches the configured length. csr_write_data sets that length.
//   timing: the block takes one request and holds req_stall high until done.
//   a flag byte or a reference first byte passes the decode state only, a
//   literal the decode and write states, and a reference the decode state
//   and then a read and a write state per copied byte (length 3 to 18).
//   reset clears the sequencer state, not all registers; history entries
//   not yet written since stream start read as zero, with no clearing pass.
//   when rsp_stall is high the output register holds its byte and the copy
//   loop waits; a new request can still be taken while a byte waits.
// ----------------------------------------------------------------------------
module lzss_ring_decoder
   import lzsd_pkg::*;
#(
   parameter int HISTORY_SIZE = HISTORY_SIZE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first,
   input  logic        req_last_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_run_last,
   output logic        rsp_stream_done,
   input  logic        csr_write_en,
   input  logic [23:0] csr_write_data
);

   localparam int AW = $clog2(HISTORY_SIZE);

   hist_ctl_type  hist_ctl;
   logic [AW-1:0] hist_wr_addr;
   logic [7:0]    hist_wr_data;
   logic [AW-1:0] hist_rd_addr;
   logic [7:0]    hist_rd_data;

   lzsd_ctrl #(
      .HISTORY_SIZE (HISTORY_SIZE)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_first       (req_first),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .hist_ctl        (hist_ctl),
      .hist_wr_addr    (hist_wr_addr),
      .hist_wr_data    (hist_wr_data),
      .hist_rd_addr    (hist_rd_addr),
      .hist_rd_data    (hist_rd_data)
   );

   lzsd_history #(
      .HISTORY_SIZE (HISTORY_SIZE)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .hist_ctl (hist_ctl),
      .wr_addr  (hist_wr_addr),
      .wr_data  (hist_wr_data),
      .rd_addr  (hist_rd_addr),
      .rd_data  (hist_rd_data)
   );

endmodule

### design/lzsd_checker.sv
// ----------------------------------------------------------------------------
// lzsd_checker
// port-level assertions for the lzss ring decoder
// ----------------------------------------------------------------------------
module lzsd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [7:0]  rsp_out_byte,
   input logic        rsp_run_last,
   input logic        rsp_stream_done
);

   // one request at a time
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while previous request still in work");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stream_done) |-> rsp_run_last)
      else $error("stream done on a byte that is not the last of its request");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_out_byte) && $stable(rsp_run_last)
          && $stable(rsp_stream_done)))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && !req_stall))
      else $error("outputs not idle after reset");

endmodule

bind lzss_ring_decoder lzsd_checker u_lzsd_checker (.*);

### tb/lzss_ring_decoder_checker.sv
// ----------------------------------------------------------------------------
// lzss_ring_decoder_checker
// Watches the request, response and csr ports of the lzss ring decoder. Each
// accepted request is decoded by a local copy of the decoder, and the bytes it
// yields are queued. Each accepted response byte is compared with the oldest
// queued byte. The module reports the number of queued bytes and the number
// of mismatches.
// ----------------------------------------------------------------------------
module lzss_ring_decoder_checker
   import lzsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_first,
   input  logic        req_last_in,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_run_last,
   input  logic        rsp_stream_done,
   input  logic        csr_write_en,
   input  logic [23:0] csr_write_data,
   output int          pending,
   output int          errors
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       stream_done;
   } plain_byte_type;

   plain_byte_type expected_bytes[$];

   logic [7:0]  window_mem [HISTORY_SIZE_DEF];
   logic [11:0] wr_ptr;
   logic [7:0]  flag_reg;
   logic [3:0]  flags_todo;
   phase_type   ph;
   logic [7:0]  ref_lo;
   logic [23:0] produced;
   logic [23:0] length_cfg;

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 100) begin
         $display("%0t ns mismatch on %s: got %0h, expected %0h", $time, what, got, want);
      end
      errors++;
   endtask

   task automatic restart_stream();
      int i;
      for (i = 0; i < HISTORY_SIZE_DEF; i++) begin
         window_mem[i] = 8'h00;
      end
      wr_ptr     = START_POS;
      flag_reg   = 8'h00;
      flags_todo = 4'd0;
      ph         = PH_FLAG;
      ref_lo     = 8'h00;
      produced   = 24'd0;
   endtask

   task automatic put_byte(input logic [7:0] v);
      plain_byte_type rec;
      window_mem[wr_ptr] = v;
      wr_ptr             = wr_ptr + 12'd1;
      produced           = produced + 24'd1;
      rec.data           = v;
      rec.run_last       = 1'b0;
      rec.stream_done    = (produced == length_cfg);
      expected_bytes.push_back(rec);
      if (produced == length_cfg) begin
         ph = PH_DONE;
      end
   endtask

   task automatic shift_flag();
      flag_reg = flag_reg << 1;
      if (flags_todo != 4'd0) begin
         flags_todo = flags_todo - 4'd1;
      end
      ph = (flags_todo != 4'd0) ? PH_DATA : PH_FLAG;
   endtask

   task automatic decode_request(input logic [7:0] b, input logic f, input logic l);
      int             n0;
      int             j;
      logic [4:0]     count;
      logic [11:0]    src;
      plain_byte_type rec;
      n0 = expected_bytes.size();
      if (f) begin
         restart_stream();
      end
      if (ph != PH_DONE && produced >= length_cfg) begin
         ph = PH_DONE;
      end
      case (ph)
         PH_FLAG: begin
            flag_reg   = b;
            flags_todo = FLAGS_PER_BYTE;
            ph         = PH_DATA;
         end
         PH_DATA: begin
            if (flag_reg[LIT_FLAG_BIT]) begin
               put_byte(b);
               if (ph != PH_DONE) begin
                  shift_flag();
               end
            end else begin
               ref_lo = b;
               ph     = PH_SECOND;
            end
         end
         PH_SECOND: begin
            count = {1'b0, ref_lo[3:0]} + LEN_BIAS;
            src   = {b, ref_lo[7:4]};
            for (j = 0; j < count && produced < length_cfg; j++) begin
               put_byte(window_mem[src]);
               src = src + 12'd1;
            end
            if (ph != PH_DONE) begin
               shift_flag();
            end
         end
         default: ;
      endcase
      if (l) begin
         ph = PH_DONE;
      end
      if (expected_bytes.size() > n0) begin
         rec = expected_bytes.pop_back();
         rec.run_last = 1'b1;
         expected_bytes.push_back(rec);
      end
   endtask

   always @(posedge clock) begin
      plain_byte_type rec;
      if (reset) begin
         restart_stream();
         length_cfg = 24'd0;
         expected_bytes.delete();
         errors = 0;
      end else begin
         if (csr_write_en) begin
            length_cfg = csr_write_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("unexpected byte", rsp_out_byte, 0);
            end else begin
               rec = expected_bytes.pop_front();
               if (rsp_out_byte !== rec.data) begin
                  report_mismatch("out_byte", rsp_out_byte, rec.data);
               end
               if (rsp_run_last !== rec.run_last) begin
                  report_mismatch("run_last", rsp_run_last, rec.run_last);
               end
               if (rsp_stream_done !== rec.stream_done) begin
                  report_mismatch("stream_done", rsp_stream_done, rec.stream_done);
               end
            end
         end
         if (req_valid && !req_stall) begin
            decode_request(req_in_byte, req_first, req_last_in);
         end
      end
      pending = expected_bytes.size();
   end

endmodule

### tb/lzss_ring_decoder_tb.sv
// ----------------------------------------------------------------------------
// lzss_ring_decoder_tb
// Stimulus and verdict for the lzss ring decoder. A short directed part covers
// literals, long and overlapping references, window wrap, truncation at the
// configured length, streams cut short and ignored bytes. A random part
// follows with mostly well-formed compressed streams, plus broken streams and
// noise. Sender idling and receiver stalls vary from phase to phase, and one
// phase holds off the receiver for a long stretch. The checker module
// compares the results.
// ----------------------------------------------------------------------------
module lzss_ring_decoder_tb
   import lzsd_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_in_byte;
   logic        req_first;
   logic        req_last_in;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_out_byte;
   logic        rsp_run_last;
   logic        rsp_stream_done;
   logic        csr_write_en;
   logic [23:0] csr_write_data;
   int          pending;
   int          errors;

   int          send_idle_pct;
   int          rsp_stall_pct;
   int          hold_cycles;
   logic [7:0]  stream_bytes[$];

   lzss_ring_decoder dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_first       (req_first),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   lzss_ring_decoder_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_in_byte     (req_in_byte),
      .req_first       (req_first),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_last    (rsp_run_last),
      .rsp_stream_done (rsp_stream_done),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data),
      .pending         (pending),
      .errors          (errors)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // receiver: random stalls, or a long hold-off when requested
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("lzss_ring_decoder_tb NOT OK");
      $finish;
   end

   task automatic send_item(input logic [7:0] b, input logic f, input logic l);
      int gap;
      gap = 0;
      while (gap < 20 && $urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_first   <= f;
      req_last_in <= l;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_length(input logic [23:0] len);
      quiesce();
      csr_write_en   <= 1'b1;
      csr_write_data <= len;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // compressed stream with references aimed mostly at recent output
   task automatic build_stream(input int groups);
      int          g;
      int          k;
      int          back_off;
      logic [7:0]  flags;
      logic [3:0]  len_code;
      logic [11:0] src;
      logic [11:0] gen_pos;
      stream_bytes.delete();
      gen_pos = START_POS;
      for (g = 0; g < groups; g++) begin
         flags = 8'($urandom);
         stream_bytes.push_back(flags);
         for (k = 7; k >= 0; k--) begin
            if (flags[k]) begin
               stream_bytes.push_back(8'($urandom));
               gen_pos = gen_pos + 12'd1;
            end else begin
               len_code = 4'($urandom);
               if ($urandom_range(3) == 0) begin
                  src = 12'($urandom);
               end else begin
                  back_off = $urandom_range(1, 24);
                  src      = gen_pos - 12'(back_off);
               end
               stream_bytes.push_back({src[3:0], len_code});
               stream_bytes.push_back(src[11:4]);
               gen_pos = gen_pos + 12'(len_code) + 12'd3;
            end
         end
      end
   endtask

   initial begin : stimulus
      int mode;
      int items_in_mode;
      int pick;
      int cut;
      int k;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_in_byte    = 8'h00;
      req_first      = 1'b0;
      req_last_in    = 1'b0;
      csr_write_en   = 1'b0;
      csr_write_data = 24'd0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      hold_cycles    = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // literals, long overlapping reference, window wrap, cut mid-reference
      set_length(24'hFFFFFF);
      send_item(8'hA5, 1'b1, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'hDF, 1'b0, 1'b0);
      send_item(8'hFE, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h10, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'hF5, 1'b0, 1'b0);
      send_item(8'hFF, 1'b0, 1'b0);
      send_item(8'h80, 1'b0, 1'b0);
      send_item(8'h3A, 1'b0, 1'b1);
      send_item(8'h42, 1'b0, 1'b0);
      // first and last on one request
      send_item(8'h00, 1'b1, 1'b1);
      // reference cut short at the configured length
      set_length(24'd5);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h0F, 1'b0, 1'b0);
      send_item(8'h00, 1'b0, 1'b0);
      send_item(8'h99, 1'b0, 1'b0);
      // length lowered mid-stream
      set_length(24'hFFFFFF);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h3C, 1'b0, 1'b0);
      send_item(8'hC3, 1'b0, 1'b0);
      set_length(24'd1);
      send_item(8'h55, 1'b0, 1'b0);
      // literal carrying last
      set_length(24'hFFFFFF);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h01, 1'b0, 1'b1);
      // zero length
      set_length(24'd0);
      send_item(8'hFF, 1'b1, 1'b0);
      send_item(8'h12, 1'b0, 1'b0);

      for (mode = 0; mode < 4; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 46;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 46;
            end
            default: begin
               send_idle_pct = 38;
               rsp_stall_pct = 38;
            end
         endcase
         items_in_mode = 0;
         while (items_in_mode < 45) begin
            pick = $urandom_range(19);
            if (pick == 0) begin
               set_length(24'd0);
            end else if (pick < 4) begin
               set_length(24'($urandom_range(1, 40)));
            end else if (pick < 6) begin
               set_length(24'($urandom_range(41, 400)));
            end else begin
               set_length(24'hFFFFFF);
            end
            if (mode == 0 && items_in_mode == 0) begin
               hold_cycles = 300;
            end
            pick = $urandom_range(9);
            if (pick == 0) begin
               cut = $urandom_range(1, 12);
               repeat (cut) begin
                  send_item(8'($urandom), $urandom_range(9) == 0, $urandom_range(9) == 0);
               end
               items_in_mode += cut;
            end else begin
               build_stream($urandom_range(1, 3));
               // broken streams end early with last on a random request
               if (pick == 1) begin
                  cut = $urandom_range(stream_bytes.size() - 1);
               end else begin
                  cut = stream_bytes.size() - 1;
               end
               for (k = 0; k <= cut; k++) begin
                  send_item(stream_bytes[k], k == 0, k == cut);
               end
               items_in_mode += cut + 1;
               if ($urandom_range(3) == 0) begin
                  send_item(8'($urandom), 1'b0, 1'b0);
                  items_in_mode++;
               end
            end
         end
      end

      quiesce();
      if (errors == 0) begin
         $display("lzss_ring_decoder_tb OK");
      end else begin
         $display("lzss_ring_decoder_tb NOT OK");
      end
      $finish;
   end

endmodule
